FILE: rtl/hmqs_pkg.sv
// package: types, constants and helpers for the quadratic-sequence heap merger
`default_nettype none
package hmqs_pkg;

   localparam int unsigned MaxFunctionsDefault = 1024;
   localparam int unsigned ValueWidth = 49;
   localparam int unsigned IndexWidth = 10;
   localparam int unsigned PointWidth = 16;
   localparam int unsigned CoefWidth = 16;
   localparam logic [PointWidth-1:0] PointMax = 16'hFFFF;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef struct packed {
      op_type                operation;
      logic [CoefWidth-1:0]  coef_a;
      logic [CoefWidth-1:0]  coef_b;
      logic [CoefWidth-1:0]  coef_c;
   } req_type;

   typedef struct packed {
      logic [ValueWidth-1:0] min_value;
      logic [IndexWidth-1:0] source_index;
      logic [PointWidth-1:0] point;
      logic                  empty_flag;
   } rsp_type;

   // datapath commands issued by the controller
   typedef struct packed {
      logic capture;      // latch request beat
      logic coef_read;    // read coefficients of working function
      logic mul1;         // a*x+b
      logic mul2;         // (a*x+b)*x+c
      logic eval_done;    // fill working entry with the value
      logic read_nodes;   // read children (pop) or parent (load)
      logic compare;      // pick best of working entry and children or parent
      logic write_node;   // write working entry / swapped entry
      logic move_down;    // descend to chosen child
      logic move_up;      // ascend to parent
      logic write_coef;   // store coefficients
      logic count_inc;
      logic emit;
      logic emit_empty;
      logic load_root;    // take root as working entry for a pop
   } cmd_type;

   typedef struct packed {
      logic is_pop;
      logic table_full;
      logic heap_empty;
      logic at_root;
      logic stop_down;    // no child beats working entry
      logic stop_up;      // parent does not lose to working entry
   } sts_type;

   // heap order: true if (va,sa) must sit above (vb,sb)
   function automatic logic ranks_above(input logic [ValueWidth-1:0] va,
                                        input logic [IndexWidth-1:0] sa,
                                        input logic [ValueWidth-1:0] vb,
                                        input logic [IndexWidth-1:0] sb);
      if (va != vb) begin
         return va < vb;
      end
      return sa < sb;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/hmqs_ram.sv
// generic single-port-write, dual-read RAM with registered read
`default_nettype none
module hmqs_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr_a,
   output      logic [Width-1:0]         rd_data_a,
   input  wire logic [$clog2(Depth)-1:0] rd_addr_b,
   output      logic [Width-1:0]         rd_data_b
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end
endmodule
`default_nettype wire

FILE: rtl/hmqs_datapath.sv
// datapath: coefficient store, heap store, evaluator and sift logic
`default_nettype none
module hmqs_datapath
   import hmqs_pkg::*;
#(
   parameter int unsigned MaxFunctions = MaxFunctionsDefault
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_beat,
   input  wire cmd_type cmd,
   output      sts_type sts,
   output      rsp_type rsp_data
);
   localparam int unsigned AW = $clog2(MaxFunctions);
   localparam int unsigned CW = $clog2(MaxFunctions + 1);
   localparam int unsigned EW = ValueWidth + IndexWidth + PointWidth;

   req_type req_ff;
   logic [CW-1:0] count_ff;
   logic [AW-1:0] pos_ff, pos_in;          // hole position of the working entry
   logic [AW-1:0] fn_ff;                   // function being evaluated
   logic [PointWidth-1:0] x_ff;
   logic [ValueWidth-1:0] acc_ff;
   logic [ValueWidth-1:0] wv_ff;
   logic [IndexWidth-1:0] ws_ff;
   logic [PointWidth-1:0] wp_ff;
   logic [3*CoefWidth-1:0] coef_rd, coef_unused;
   logic [EW-1:0] heap_rd_a, heap_rd_b;
   logic [EW-1:0] heap_wdata;
   logic [AW-1:0] heap_waddr, rd_a, rd_b;
   logic heap_we;
   logic [AW:0] child_l;
   logic [ValueWidth-1:0] bv_ff;
   logic [IndexWidth-1:0] bs_ff;
   logic [PointWidth-1:0] bp_ff;
   logic [AW-1:0] bpos_ff;
   logic best_child_ff;

   // coefficient store
   hmqs_ram #(.Width(3*CoefWidth), .Depth(MaxFunctions)) u_coef (
      .clock    (clock),
      .wr_en    (cmd.write_coef),
      .wr_addr  (count_ff[AW-1:0]),
      .wr_data  ({req_ff.coef_a, req_ff.coef_b, req_ff.coef_c}),
      .rd_addr_a(fn_ff),
      .rd_data_a(coef_rd),
      .rd_addr_b(fn_ff),
      .rd_data_b(coef_unused)
   );

   // heap store: value, source, point
   always_comb begin
      child_l = {pos_ff, 1'b0} + {{AW{1'b0}}, 1'b1};
      rd_a = pos_ff;
      rd_b = pos_ff;
      if (cmd.read_nodes) begin
         if (req_ff.operation == OP_POP) begin
            rd_a = child_l[AW-1:0];
            rd_b = child_l[AW-1:0] + {{(AW-1){1'b0}}, 1'b1};
         end else begin
            rd_a = (pos_ff - {{(AW-1){1'b0}}, 1'b1}) >> 1;
         end
      end
   end

   hmqs_ram #(.Width(EW), .Depth(MaxFunctions)) u_heap (
      .clock    (clock),
      .wr_en    (heap_we),
      .wr_addr  (heap_waddr),
      .wr_data  (heap_wdata),
      .rd_addr_a(rd_a),
      .rd_data_a(heap_rd_a),
      .rd_addr_b(rd_b),
      .rd_data_b(heap_rd_b)
   );

   logic [ValueWidth-1:0] av, bv;
   logic [IndexWidth-1:0] as, bs;
   logic [PointWidth-1:0] ap, bp;
   logic a_ok, b_ok;
   logic [AW:0] child_r;
   assign {av, as, ap} = heap_rd_a;
   assign {bv, bs, bp} = heap_rd_b;
   assign child_r = child_l + {{AW{1'b0}}, 1'b1};
   assign a_ok = ({1'b0, child_l} < {1'b0, count_ff});
   assign b_ok = ({1'b0, child_r} < {1'b0, count_ff});

   // write: on stop, the working entry lands at pos; on move, the displaced
   // entry moves into the hole
   always_comb begin
      heap_we = cmd.write_node;
      heap_waddr = pos_ff;
      heap_wdata = {wv_ff, ws_ff, wp_ff};
      if (cmd.move_down || cmd.move_up) begin
         heap_wdata = {bv_ff, bs_ff, bp_ff};
      end
      pos_in = pos_ff;
      if (cmd.move_down || cmd.move_up) begin
         pos_in = bpos_ff;
      end
   end

   logic [2*CoefWidth-1:0] prod1;
   logic [ValueWidth-1:0] prod2;
   assign prod1 = coef_rd[3*CoefWidth-1:2*CoefWidth] * x_ff;
   assign prod2 = ValueWidth'(acc_ff * x_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.count_inc) begin
         count_ff <= count_ff + CW'(1);
      end
      if (cmd.capture) begin
         req_ff <= req_beat;
         fn_ff  <= count_ff[AW-1:0];
         // a pop starts at the root, a load at the next free slot
         pos_ff <= (req_beat.operation == OP_POP) ? '0 : count_ff[AW-1:0];
         x_ff   <= PointWidth'(1);
      end
      if (cmd.load_root) begin
         fn_ff  <= AW'(heap_rd_a[PointWidth +: IndexWidth]);
         ws_ff  <= heap_rd_a[PointWidth +: IndexWidth];
         pos_ff <= '0;
         x_ff   <= (heap_rd_a[PointWidth-1:0] != PointMax)
                   ? heap_rd_a[PointWidth-1:0] + PointWidth'(1) : PointMax;
      end
      if (cmd.mul1) begin
         acc_ff <= ValueWidth'(prod1) + ValueWidth'(coef_rd[2*CoefWidth-1:CoefWidth]);
      end
      if (cmd.mul2) begin
         acc_ff <= prod2 + ValueWidth'(coef_rd[CoefWidth-1:0]);
      end
      if (cmd.eval_done) begin
         wv_ff <= acc_ff;
         wp_ff <= x_ff;
         if (req_ff.operation == OP_LOAD) begin
            ws_ff <= IndexWidth'(fn_ff);
         end
      end
      if (cmd.compare) begin
         // load: parent is in port a; pop: children in a, b
         if (req_ff.operation == OP_LOAD) begin
            best_child_ff <= ranks_above(wv_ff, ws_ff, av, as);
            {bv_ff, bs_ff, bp_ff} <= heap_rd_a;
            bpos_ff <= (pos_ff - {{(AW-1){1'b0}}, 1'b1}) >> 1;
         end else if (b_ok && ranks_above(bv, bs, av, as)) begin
            best_child_ff <= ranks_above(bv, bs, wv_ff, ws_ff);
            {bv_ff, bs_ff, bp_ff} <= heap_rd_b;
            bpos_ff <= child_r[AW-1:0];
         end else begin
            best_child_ff <= a_ok && ranks_above(av, as, wv_ff, ws_ff);
            {bv_ff, bs_ff, bp_ff} <= heap_rd_a;
            bpos_ff <= child_l[AW-1:0];
         end
      end
      if (cmd.move_down || cmd.move_up) begin
         pos_ff <= pos_in;
      end
      if (cmd.emit) begin
         rsp_data.min_value    <= av;
         rsp_data.source_index <= as;
         rsp_data.point        <= ap;
         rsp_data.empty_flag   <= 1'b0;
      end
      if (cmd.emit_empty) begin
         rsp_data <= '{empty_flag: 1'b1, default: '0};
      end
   end

   assign sts.is_pop     = (req_ff.operation == OP_POP);
   assign sts.table_full = (count_ff >= CW'(MaxFunctions));
   assign sts.heap_empty = (count_ff == '0);
   assign sts.at_root    = (pos_ff == '0);
   assign sts.stop_down  = !best_child_ff;
   assign sts.stop_up    = !best_child_ff;

   // second coefficient read port is unused
   logic unused_ok;
   assign unused_ok = ^coef_unused;
   property count_bounded;
      @(posedge clock) disable iff (reset) count_ff <= CW'(MaxFunctions);
   endproperty
   a_count: assert property (count_bounded) else $error("count overflow");
   a_full_no_inc: assert property (@(posedge clock) disable iff (reset)
      cmd.count_inc |-> !sts.table_full) else $error("load into full table");
   a_one_move: assert property (@(posedge clock) disable iff (reset)
      !(cmd.move_down && cmd.move_up)) else $error("conflicting moves");
endmodule
`default_nettype wire

FILE: rtl/hmqs_ctrl.sv
// controller: sequences load and pop operations over the datapath
`default_nettype none
module hmqs_ctrl
   import hmqs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output      logic    busy,
   output      logic    rsp_valid,
   input  wire sts_type sts,
   output      cmd_type cmd
);
   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_DEC   = 11'b00000000010,
      S_ROOT  = 11'b00000000100,
      S_COEF  = 11'b00000001000,
      S_MUL1  = 11'b00000010000,
      S_MUL2  = 11'b00000100000,
      S_EVAL  = 11'b00001000000,
      S_READ  = 11'b00010000000,
      S_CMP   = 11'b00100000000,
      S_STEP  = 11'b01000000000,
      S_EMIT  = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic root_wait_ff;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            if (sts.is_pop) begin
               if (sts.heap_empty) begin
                  cmd.emit_empty = 1'b1;
                  state_in = S_EMIT;
               end else begin
                  state_in = S_ROOT;   // root read under way (pos = 0)
               end
            end else if (sts.table_full) begin
               state_in = S_IDLE;
            end else begin
               cmd.write_coef = 1'b1;
               state_in = S_COEF;
            end
         end
         S_ROOT: begin
            // root data arrives; report it and start re-evaluation
            if (root_wait_ff) begin
               cmd.emit = 1'b1;
               cmd.load_root = 1'b1;
               state_in = S_COEF;
            end
         end
         S_COEF: state_in = S_MUL1;
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval_done = 1'b1;
            if (!sts.is_pop) begin
               cmd.count_inc = 1'b1;
            end
            state_in = S_READ;
         end
         S_READ: begin
            if (!sts.is_pop && sts.at_root) begin
               cmd.write_node = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.read_nodes = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            cmd.compare = 1'b1;
            state_in = S_STEP;
         end
         S_STEP: begin
            cmd.write_node = 1'b1;
            if (sts.stop_down) begin
               state_in = sts.is_pop ? S_EMIT : S_IDLE;
            end else begin
               if (sts.is_pop) begin
                  cmd.move_down = 1'b1;
               end else begin
                  cmd.move_up = 1'b1;
               end
               state_in = S_READ;
            end
         end
         S_EMIT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         root_wait_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         root_wait_ff <= (state_ff == S_ROOT) ? !root_wait_ff : 1'b0;
         rsp_valid <= cmd.emit || cmd.emit_empty;
      end
   end

   assign busy = (state_ff != S_IDLE);

   a_emit_from_pop: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit || cmd.emit_empty) |-> sts.is_pop) else $error("result on a load");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> state_ff == S_IDLE) else $error("capture while busy");
   a_write_once: assert property (@(posedge clock) disable iff (reset)
      cmd.write_coef |=> !cmd.write_coef) else $error("double coefficient write");
endmodule
`default_nettype wire

FILE: rtl/heap_merge_of_quadratic_sequences.sv
// top level: k-way merge of quadratic sequences on a binary min-heap
//
// usage
//   raise start with a request beat on req_data while busy is low; the beat
//   is taken at that edge. operation load stores a function's coefficients
//   under the next free index and inserts its value at x = 1; a load into a
//   full table is dropped. operation pop yields one result beat on rsp_data
//   with rsp_valid high for exactly one cycle: the smallest value, its
//   function index and point, or empty_flag on an empty heap.
//   the receiver cannot stall: every result beat must be taken as shown.
//   flow: a load passes decode, coefficient read, the multiply steps and
//   evaluation, then climbs; a load that reaches the root writes its entry
//   there from the read state. a pop reads the root, strobes it as the
//   result beat, re-evaluates that function at its next point and sifts
//   down; an empty pop strobes its result from the decode state. one
//   request is worked at a time; each sift level walks the read, compare
//   and step states through the dual-read heap memory.
//   reset clears the function count and control state; the memories need
//   no clearing since entries are only used after being written.
`default_nettype none
module heap_merge_of_quadratic_sequences
   import hmqs_pkg::*;
#(
   parameter int unsigned MaxFunctions = MaxFunctionsDefault
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output      logic    busy,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   output      rsp_type rsp_data
);
   cmd_type cmd;   // controller to datapath
   sts_type sts;   // datapath to controller

   hmqs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .sts      (sts),
      .cmd      (cmd)
   );

   hmqs_datapath #(.MaxFunctions(MaxFunctions)) u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_beat(req_data),
      .cmd     (cmd),
      .sts     (sts),
      .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire
